@@ design/nested_delimiter_token_skipper_defines.svh @@
// Assertion macros used by the skipper top level.
// Each macro expects clk and rst_n in scope at the place of use.
`ifndef NESTED_DELIMITER_TOKEN_SKIPPER_DEFINES_SVH
`define NESTED_DELIMITER_TOKEN_SKIPPER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define NDS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nds: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define NDS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nds: next-cycle check failed");

`endif

@@ design/nds_pkg.sv @@
// Types and constants for the nested delimiter token skipper.
// No dependencies; imported by the top level.
package nds_pkg;

  localparam logic [7:0] KIND_EOF      = 8'd0;
  localparam logic [7:0] KIND_LPAREN   = 8'd1;
  localparam logic [7:0] KIND_LBRACKET = 8'd2;
  localparam logic [7:0] KIND_LBRACE   = 8'd3;
  localparam logic [7:0] KIND_RPAREN   = 8'd4;
  localparam logic [7:0] KIND_RBRACKET = 8'd5;
  localparam logic [7:0] KIND_RBRACE   = 8'd6;
  localparam logic [7:0] CLOSE_TO_OPEN = 8'd3;

  localparam int REG_SLOTS = 4;

  typedef logic [1:0] opener_t;

  typedef enum logic [2:0] {
    CFG_STOP_A     = 3'd0,
    CFG_STOP_B     = 3'd1,
    CFG_STOP_C     = 3'd2,
    CFG_STOP_D     = 3'd3,
    CFG_STOP_COUNT = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic       stop_here;
    logic [5:0] nest_depth;
    logic       overflow;
  } res_t;

endpackage

@@ design/nested_delimiter_token_skipper.sv @@
// Top level of the nested delimiter token skipper.
// Depends on nds_pkg, nds_ram and nested_delimiter_token_skipper_defines.svh.
//
// Takes one token item per clock while in_stall is low and returns one result
// item per token from the result register. The top of the opener stack
// sits in a register; the entry beneath it is read ahead from the stack RAM
// every cycle, so push, pop and the stop compare all complete in the cycle
// the item is accepted. A two-entry output buffer (result register plus skid
// register) lets in_stall rise only when both hold an unread result. The
// stack RAM needs no clearing pass after reset.
`include "nested_delimiter_token_skipper_defines.svh"

module nested_delimiter_token_skipper
  import nds_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  parameter int STOP_SLOTS  = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_token_kind,
  input  logic       in_begin_skip,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_stop_here,
  output logic [5:0] out_nest_depth,
  output logic       out_overflow
);

  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int AW        = $clog2(STACK_DEPTH);
  localparam int USED_REGS = (STOP_SLOTS < REG_SLOTS) ? STOP_SLOTS : REG_SLOTS;

  logic [7:0]    stop_kind_r [REG_SLOTS];
  logic [2:0]    stop_count_r;
  logic [CW-1:0] count_r, count_nxt, cnt_base, rd_sub;
  opener_t       top_r, top_nxt, below;
  logic          out_valid_r, skid_valid_r;
  res_t          res_r, skid_r, res_nxt;
  logic          in_acc, out_acc;
  logic          stop_match, stop, is_open, is_close, push, ovf, push_ok, pop;

  assign in_acc  = in_valid && !skid_valid_r;
  assign out_acc = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_SLOTS; i++) begin
        stop_kind_r[i] <= '0;
      end
      stop_count_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STOP_A:     stop_kind_r[0] <= cfg_data;
        CFG_STOP_B:     stop_kind_r[1] <= cfg_data;
        CFG_STOP_C:     stop_kind_r[2] <= cfg_data;
        CFG_STOP_D:     stop_kind_r[3] <= cfg_data;
        CFG_STOP_COUNT: stop_count_r   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stop_match = 1'b0;
    for (int i = 0; i < USED_REGS; i++) begin
      if (3'(i) < stop_count_r && stop_kind_r[i] == in_token_kind) begin
        stop_match = 1'b1;
      end
    end
  end

  always_comb begin
    cnt_base = in_begin_skip ? '0 : count_r;
    stop     = (in_token_kind == KIND_EOF) || (cnt_base == '0 && stop_match);
    is_open  = in_token_kind >= KIND_LPAREN && in_token_kind <= KIND_LBRACE;
    is_close = in_token_kind >= KIND_RPAREN && in_token_kind <= KIND_RBRACE;
    push     = !stop && is_open;
    ovf      = push && cnt_base == CW'(STACK_DEPTH);
    push_ok  = push && !ovf;
    pop      = !stop && is_close && cnt_base != '0 &&
               top_r == 2'(in_token_kind - CLOSE_TO_OPEN);

    count_nxt = count_r;
    top_nxt   = top_r;
    if (in_acc) begin
      count_nxt = cnt_base;
      if (push_ok) begin
        count_nxt = cnt_base + CW'(1);
        top_nxt   = in_token_kind[1:0];
      end else if (pop) begin
        count_nxt = cnt_base - CW'(1);
        top_nxt   = below;
      end
    end
    rd_sub = count_nxt - CW'(2);

    res_nxt.stop_here  = stop;
    res_nxt.nest_depth = 6'(count_nxt);
    res_nxt.overflow   = ovf;
  end

  nds_ram #(
    .WIDTH ($bits(opener_t)),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (in_acc && push_ok),
    .waddr (cnt_base[AW-1:0]),
    .wdata (in_token_kind[1:0]),
    .raddr (rd_sub[AW-1:0]),
    .rdata (below)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    top_r <= top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (!out_valid_r || out_acc) begin
        out_valid_r  <= skid_valid_r || in_acc;
        skid_valid_r <= 1'b0;
      end else if (in_acc) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_acc) begin
      res_r <= skid_valid_r ? skid_r : res_nxt;
    end else if (in_acc) begin
      skid_r <= res_nxt;
    end
  end

  assign in_stall       = skid_valid_r;
  assign out_valid      = out_valid_r;
  assign out_stop_here  = res_r.stop_here;
  assign out_nest_depth = res_r.nest_depth;
  assign out_overflow   = res_r.overflow;

  `NDS_ASSERT_IMP(a_depth_bound, 1'b1, count_r <= CW'(STACK_DEPTH))
  `NDS_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r)
  `NDS_ASSERT_IMP(a_ovf_when_full, in_acc && ovf, cnt_base == CW'(STACK_DEPTH))
  `NDS_ASSERT_NXT(a_stop_keeps_stack, in_acc && stop && !in_begin_skip,
                  count_r == $past(count_r))
  `NDS_ASSERT_NXT(a_push_top, in_acc && push_ok,
                  top_r == $past(in_token_kind[1:0]) && count_r == $past(cnt_base) + CW'(1))

endmodule

@@ design/nds_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the opener stack of the skipper.
module nds_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
